// ----- design/ktb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ktb_pkg: shared types and constants of the keyed token bucket limiter
// Request and result layouts, table entry layout, arithmetic unit control
// and configuration register indexes.
// ----------------------------------------------------------------------------
package ktb_pkg;

  // default sizing
  localparam int unsigned TableEntriesDef = 256;
  localparam int unsigned TokenFracDef    = 32;

  // fixed field widths
  localparam int unsigned KeyW   = 32;
  localparam int unsigned TimeW  = 48;
  localparam int unsigned TokW   = 48;
  localparam int unsigned RateW  = 32;
  localparam int unsigned BurstW = 16;
  localparam int unsigned CfgW   = 32;

  // register reset values
  localparam logic [RateW-1:0]  RateReset  = 32'd64425;
  localparam logic [BurstW-1:0] BurstReset = 16'd40;

  // configuration register indexes
  localparam logic RegRate  = 1'b0;
  localparam logic RegBurst = 1'b1;

  typedef struct packed {
    logic [KeyW-1:0]  client_key;
    logic [TimeW-1:0] current_time;
  } req_t;

  typedef struct packed {
    logic allowed;
    logic new_entry;
    logic table_cleared;
  } res_t;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [TokW-1:0]  tokens;
    logic [TimeW-1:0] last_time;
  } entry_t;

  // arithmetic unit operations
  typedef enum logic [2:0] {
    ARITH_NONE,
    ARITH_LOAD,
    ARITH_MUL_LO,
    ARITH_MUL_HI,
    ARITH_SUM,
    ARITH_REFILL
  } arith_op_e;

  typedef struct packed {
    arith_op_e op;
    logic      use_cap;
  } arith_ctrl_t;

endpackage
`default_nettype wire

// ----- design/ktb_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ktb_table: client bucket table
// Single write port, single registered read port memory holding key,
// token count and last timestamp of each client.
// ----------------------------------------------------------------------------
module ktb_table #(
  parameter int unsigned Entries = ktb_pkg::TableEntriesDef,
  localparam int unsigned AddrW  = $clog2(Entries)
) (
  input  wire logic             clk_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output ktb_pkg::entry_t       rd_data_o,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire ktb_pkg::entry_t  wr_data_i
);
  import ktb_pkg::*;

  entry_t mem_q [Entries];
  entry_t rd_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule
`default_nettype wire

// ----- design/ktb_arith.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ktb_arith: shared refill arithmetic unit
// One 32x32 multiplier used twice for elapsed*rate, then sum, cap clamp
// and token take, stepped by the sequencer one operation per cycle.
// ----------------------------------------------------------------------------
module ktb_arith #(
  parameter int unsigned FracBits = ktb_pkg::TokenFracDef
) (
  input  wire logic                        clk_i,
  input  wire ktb_pkg::arith_ctrl_t        ctrl_i,
  input  wire logic [ktb_pkg::TimeW-1:0]   now_i,
  input  wire logic [ktb_pkg::TimeW-1:0]   last_i,
  input  wire logic [ktb_pkg::TokW-1:0]    held_i,
  input  wire logic [ktb_pkg::RateW-1:0]   rate_i,
  input  wire logic [ktb_pkg::BurstW-1:0]  burst_i,
  output logic                             allowed_o,
  output logic [ktb_pkg::TokW-1:0]         tokens_o
);
  import ktb_pkg::*;

  localparam int unsigned Shift = 32 - FracBits;
  localparam int unsigned SumW  = 81;
  localparam logic [TokW-1:0] OneToken = TokW'(1) << FracBits;

  logic [TimeW-1:0] elapsed_q;
  logic [TokW-1:0]  held_q;
  logic [63:0]      prod_lo_q;
  logic [47:0]      prod_hi_q;
  logic [SumW-1:0]  inc_q;
  logic [TokW-1:0]  room_q;
  logic             full_q;

  logic [TokW-1:0]  cap;
  logic [31:0]      mul_a;
  logic [63:0]      mul_p;
  logic [SumW-1:0]  sum_full;

  // capacity in fixed point
  assign cap = TokW'(burst_i) << FracBits;

  // shared multiplier, low then high part of elapsed
  assign mul_a = (ctrl_i.op == ARITH_MUL_HI) ? {16'b0, elapsed_q[47:32]} : elapsed_q[31:0];
  assign mul_p = mul_a * rate_i;

  // full product, no saturation needed since any overflow exceeds the cap
  assign sum_full = {17'b0, prod_lo_q} + {1'b0, prod_hi_q, 32'b0};

  // operation registers
  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      ARITH_LOAD: begin
        if (ctrl_i.use_cap) begin
          held_q    <= cap;
          elapsed_q <= '0;
        end else begin
          held_q    <= held_i;
          elapsed_q <= now_i - last_i;
        end
      end
      ARITH_MUL_LO: begin
        prod_lo_q <= mul_p;
        room_q    <= cap - held_q;
        full_q    <= (held_q >= cap);
      end
      ARITH_MUL_HI: begin
        prod_hi_q <= mul_p[47:0];
      end
      ARITH_SUM: begin
        inc_q <= sum_full >> Shift;
      end
      ARITH_REFILL: begin
        if (full_q || (inc_q >= {33'b0, room_q})) begin
          held_q <= cap;
        end else begin
          held_q <= held_q + inc_q[TokW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // take one token if held
  assign allowed_o = (held_q >= OneToken);
  assign tokens_o  = allowed_o ? (held_q - OneToken) : held_q;

endmodule
`default_nettype wire

// ----- design/keyed_token_bucket_limiter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_token_bucket_limiter: per-client token bucket rate limiter
// Looks up the client key in a bucket table, refills its bucket from the
// elapsed time and grants the request when one whole token is held.
// ----------------------------------------------------------------------------
//  channel   | handshake           | payload
//  ----------+---------------------+------------------------------------
//  request   | start_i, busy_o     | req_i (client_key, current_time)
//  result    | done_o (strobe)     | res_o (allowed, new_entry, cleared)
//  config    | cfg_we_i            | cfg_idx_i, cfg_wdata_i
//
//  A request searches only the used table entries, and a full table is
//  emptied at accept before the search; the search reads one table entry
//  per cycle through the single table read port, then five steps of the
//  shared arithmetic unit follow.
//  busy_o is high for the whole request; the receiver cannot stall, the
//  result is on res_o for the one cycle done_o is high and a new request
//  may be accepted in that same cycle. Reset empties the table at once
//  through the fill count and loads the register reset values.
// ----------------------------------------------------------------------------
module keyed_token_bucket_limiter #(
  parameter int unsigned TableEntries = ktb_pkg::TableEntriesDef,
  parameter int unsigned TokenFracBits = ktb_pkg::TokenFracDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire ktb_pkg::req_t              req_i,
  output logic                            busy_o,
  output logic                            done_o,
  output ktb_pkg::res_t                   res_o,
  input  wire logic                       cfg_we_i,
  input  wire logic                       cfg_idx_i,
  input  wire logic [ktb_pkg::CfgW-1:0]   cfg_wdata_i
);
  import ktb_pkg::*;

  localparam int unsigned AddrW = $clog2(TableEntries);
  localparam int unsigned IdxW  = $clog2(TableEntries + 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SEARCH = 7'b0000010,
    S_MUL_LO = 7'b0000100,
    S_MUL_HI = 7'b0001000,
    S_SUM    = 7'b0010000,
    S_REFILL = 7'b0100000,
    S_WRITE  = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [KeyW-1:0]  key_q, key_d;
  logic [TimeW-1:0] now_q, now_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             pend_q, pend_d;
  logic [IdxW-1:0]  used_q, used_d;
  logic [AddrW-1:0] slot_q, slot_d;
  logic             fresh_q, fresh_d;
  logic             cleared_q, cleared_d;
  logic [RateW-1:0] rate_q;
  logic [BurstW-1:0] burst_q;
  logic             done_q;
  res_t             res_q;

  logic             accept;
  logic             hit;
  logic [IdxW-1:0]  idx_m1;
  logic             rd_en;
  entry_t           rd_data;
  logic             wr_en;
  entry_t           wr_data;
  arith_ctrl_t      arith_ctrl;
  logic             allowed;
  logic [TokW-1:0]  tokens;

  assign accept = start_i && (state_q == S_IDLE);
  assign hit    = pend_q && (rd_data.key == key_q);
  assign idx_m1 = idx_q - IdxW'(1);

  // sequencer
  always_comb begin
    state_d         = state_q;
    key_d           = key_q;
    now_d           = now_q;
    idx_d           = idx_q;
    pend_d          = 1'b0;
    used_d          = used_q;
    slot_d          = slot_q;
    fresh_d         = fresh_q;
    cleared_d       = cleared_q;
    rd_en           = 1'b0;
    wr_en           = 1'b0;
    arith_ctrl.op      = ARITH_NONE;
    arith_ctrl.use_cap = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          key_d     = req_i.client_key;
          now_d     = req_i.current_time;
          idx_d     = '0;
          fresh_d   = 1'b0;
          cleared_d = 1'b0;
          if (used_q == IdxW'(TableEntries)) begin
            used_d    = '0;
            cleared_d = 1'b1;
          end
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (hit) begin
          slot_d        = idx_m1[AddrW-1:0];
          arith_ctrl.op = ARITH_LOAD;
          state_d       = S_MUL_LO;
        end else if (idx_q == used_q) begin
          slot_d             = used_q[AddrW-1:0];
          used_d             = used_q + IdxW'(1);
          fresh_d            = 1'b1;
          arith_ctrl.op      = ARITH_LOAD;
          arith_ctrl.use_cap = 1'b1;
          state_d            = S_MUL_LO;
        end else begin
          rd_en  = 1'b1;
          pend_d = 1'b1;
          idx_d  = idx_q + IdxW'(1);
        end
      end
      S_MUL_LO: begin
        arith_ctrl.op = ARITH_MUL_LO;
        state_d       = S_MUL_HI;
      end
      S_MUL_HI: begin
        arith_ctrl.op = ARITH_MUL_HI;
        state_d       = S_SUM;
      end
      S_SUM: begin
        arith_ctrl.op = ARITH_SUM;
        state_d       = S_REFILL;
      end
      S_REFILL: begin
        arith_ctrl.op = ARITH_REFILL;
        state_d       = S_WRITE;
      end
      S_WRITE: begin
        wr_en   = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
      used_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      used_q  <= used_d;
      done_q  <= (state_q == S_WRITE);
    end
  end

  // request payload registers
  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    now_q     <= now_d;
    idx_q     <= idx_d;
    slot_q    <= slot_d;
    fresh_q   <= fresh_d;
    cleared_q <= cleared_d;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (state_q == S_WRITE) begin
      res_q.allowed       <= allowed;
      res_q.new_entry     <= fresh_q;
      res_q.table_cleared <= cleared_q;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q  <= RateReset;
      burst_q <= BurstReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegRate:  rate_q  <= cfg_wdata_i[RateW-1:0];
        RegBurst: burst_q <= cfg_wdata_i[BurstW-1:0];
        default: begin
        end
      endcase
    end
  end

  // table write data
  assign wr_data.key       = key_q;
  assign wr_data.tokens    = tokens;
  assign wr_data.last_time = now_q;

  ktb_table #(
    .Entries (TableEntries)
  ) u_table (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (idx_q[AddrW-1:0]),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (slot_q),
    .wr_data_i (wr_data)
  );

  ktb_arith #(
    .FracBits (TokenFracBits)
  ) u_arith (
    .clk_i     (clk_i),
    .ctrl_i    (arith_ctrl),
    .now_i     (now_q),
    .last_i    (rd_data.last_time),
    .held_i    (rd_data.tokens),
    .rate_i    (rate_q),
    .burst_i   (burst_q),
    .allowed_o (allowed),
    .tokens_o  (tokens)
  );

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

// ----- design/ktb_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ktb_checker: port level checks of the token bucket limiter
// Watches the request and result handshakes over time; bound to the top.
// ----------------------------------------------------------------------------
module ktb_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start_i,
  input wire logic          busy_o,
  input wire logic          done_o,
  input wire ktb_pkg::res_t res_o
);
  import ktb_pkg::*;

  // an accepted request makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("request accepted but block not busy");

  // busy only rises after an accepted request
  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy rose without a request");

  // result strobe comes when the work is done
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // result strobe never comes back to back
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  // an emptied table always takes the key as a new entry
  a_cleared_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.table_cleared) |-> res_o.new_entry)
    else $error("table cleared but key not new");

endmodule

bind keyed_token_bucket_limiter ktb_checker u_ktb_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .res_o   (res_o)
);
`default_nettype wire

// ----- sim/tb_keyed_token_bucket_limiter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_keyed_token_bucket_limiter: self-checking bench of the bucket limiter
// Feeds client requests through the start/busy handshake and predicts every
// verdict with a behavioral bucket table kept in the bench. Covers reset
// registers, capacity and refill extremes, clock wrap, and table flushes.
// ----------------------------------------------------------------------------
module tb_keyed_token_bucket_limiter;

  import ktb_pkg::*;

  localparam int unsigned TABLE_N     = TableEntriesDef;
  localparam int unsigned FRAC_BITS   = TokenFracDef;
  localparam logic [TokW-1:0] ONE_TOKEN = 48'd1 << FRAC_BITS;
  localparam int unsigned HOT_KEYS    = 5;
  localparam int unsigned QUIET_LIMIT = 20 * (TABLE_N + 7);

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              start_i     = 1'b0;
  req_t              req_i       = '0;
  logic              busy_o;
  logic              done_o;
  res_t              res_o;
  logic              cfg_we_i    = 1'b0;
  logic              cfg_idx_i   = RegRate;
  logic [CfgW-1:0]   cfg_wdata_i = '0;

  keyed_token_bucket_limiter u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // bench copy of the limiter state
  logic [RateW-1:0]  lim_rate  = RateReset;
  logic [BurstW-1:0] lim_burst = BurstReset;
  logic [KeyW-1:0]   bucket_key    [TABLE_N];
  logic [TokW-1:0]   bucket_tokens [TABLE_N];
  logic [TimeW-1:0]  bucket_stamp  [TABLE_N];
  int unsigned       bucket_count = 0;

  req_t        pending_reqs[$];
  res_t        expected_verdicts[$];
  res_t        want;
  logic [31:0] hot_keys [HOT_KEYS];
  logic [TimeW-1:0] req_clock = '0;
  int unsigned send_idle_pct = 31;
  int unsigned fresh_pct = 70;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned n_results = 0;
  int unsigned n_granted = 0;
  int unsigned n_fresh = 0;
  int unsigned n_flush = 0;

  wire req_taken = start_i && !busy_o;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // verdict for one request, updating the bench bucket table
  function automatic res_t predict_verdict(req_t rq);
    res_t             r;
    int unsigned      slot;
    bit               hit;
    logic [TokW-1:0]  cap;
    logic [TokW-1:0]  held;
    logic [TimeW-1:0] elapsed;
    logic [79:0]      prod_w;
    logic [63:0]      prod;
    r = '0;
    hit = 1'b0;
    slot = 0;
    cap = TokW'(lim_burst) << FRAC_BITS;
    // a full table is flushed before the lookup
    if (bucket_count >= TABLE_N) begin
      bucket_count = 0;
      r.table_cleared = 1'b1;
    end
    for (int unsigned i = 0; i < bucket_count; i++) begin
      if (!hit && bucket_key[i] == rq.client_key) begin
        slot = i;
        hit = 1'b1;
      end
    end
    // unknown client starts with a full bucket
    if (!hit) begin
      slot = bucket_count;
      bucket_key[slot] = rq.client_key;
      bucket_tokens[slot] = cap;
      bucket_stamp[slot] = rq.current_time;
      bucket_count++;
      r.new_entry = 1'b1;
    end
    // refill with a saturating product, clamp to capacity
    elapsed = rq.current_time - bucket_stamp[slot];
    prod_w = 80'(elapsed) * 80'(lim_rate);
    prod = (prod_w[79:64] != '0) ? '1 : prod_w[63:0];
    prod = prod >> (32 - FRAC_BITS);
    held = bucket_tokens[slot];
    if (held >= cap || prod >= 64'(cap - held)) held = cap;
    else held = held + prod[TokW-1:0];
    if (held >= ONE_TOKEN) begin
      held = held - ONE_TOKEN;
      r.allowed = 1'b1;
    end
    bucket_tokens[slot] = held;
    bucket_stamp[slot] = rq.current_time;
    return r;
  endfunction

  // random request: mostly forward clock steps, some wraps and jumps back
  function automatic req_t next_request();
    req_t        rq;
    logic [63:0] wide;
    int unsigned sel;
    bit          fresh;
    wide = {$urandom(), $urandom()};
    sel = $urandom_range(99);
    if (sel < 55) req_clock = req_clock + TimeW'($urandom_range(16));
    else if (sel < 75) req_clock = req_clock + TimeW'($urandom_range(5000));
    else if (sel < 85) req_clock = req_clock + wide[TimeW-1:0];
    else if (sel < 93) req_clock = req_clock - TimeW'($urandom_range(2000, 1));
    else req_clock = wide[63:64-TimeW];
    fresh = ($urandom_range(99) < fresh_pct);
    // near a full table, mix stored clients with new ones
    if (bucket_count + 2 >= TABLE_N) fresh = ($urandom_range(1) == 1);
    rq.client_key = fresh ? $urandom() : hot_keys[$urandom_range(HOT_KEYS - 1)];
    rq.current_time = req_clock;
    return rq;
  endfunction

  task automatic queue_req(input logic [KeyW-1:0] k, input logic [TimeW-1:0] t);
    req_t rq;
    rq.client_key = k;
    rq.current_time = t;
    pending_reqs.insert(pending_reqs.size(), rq);
  endtask

  // wait until every queued request has its verdict back
  task automatic drain();
    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || start_i || expected_verdicts.size() != 0);
  endtask

  task automatic write_reg(input logic idx, input logic [CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == RegRate) lim_rate = val[RateW-1:0];
    else lim_burst = val[BurstW-1:0];
  endtask

  task automatic run_random(input int unsigned n_reqs, input int unsigned idle_pct,
                            input int unsigned new_pct);
    send_idle_pct = idle_pct;
    fresh_pct = new_pct;
    repeat (n_reqs) begin
      while (pending_reqs.size() >= 2) @(posedge clk_i);
      pending_reqs.insert(pending_reqs.size(), next_request());
    end
    drain();
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      req_i   <= '0;
    end else begin
      if (req_taken) begin
        expected_verdicts.insert(expected_verdicts.size(), predict_verdict(req_i));
      end
      if (!start_i || req_taken) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          start_i <= 1'b1;
          req_i   <= pending_reqs.pop_front();
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic exp_v, input logic got_v);
    if (exp_v !== got_v) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("ERROR: result %0d field %s expected %b got %b", n_results, name,
                 exp_v, got_v);
      end
    end
  endtask

  // verdict monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result %b with no request outstanding", res_o);
        end
      end else begin
        want = expected_verdicts.pop_front();
        check_field("allowed", want.allowed, res_o.allowed);
        check_field("new_entry", want.new_entry, res_o.new_entry);
        check_field("table_cleared", want.table_cleared, res_o.table_cleared);
      end
      n_results++;
      if (res_o.allowed === 1'b1) n_granted++;
      if (res_o.new_entry === 1'b1) n_fresh++;
      if (res_o.table_cleared === 1'b1) n_flush++;
    end
  end

  // watchdog on handshake progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_taken || done_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no request or result for %0d cycles", QUIET_LIMIT);
        $display("tb_keyed_token_bucket_limiter NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    for (int i = 0; i < HOT_KEYS; i++) hot_keys[i] = $urandom();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 31;

    // reset registers: field extremes, clock wrap both ways
    queue_req(32'h0000_0000, 48'h0000_0000_0000);
    queue_req(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    queue_req(32'h0000_0000, 48'h0000_0001_0000);
    queue_req(32'h0000_0000, 48'h0000_0000_0003);
    queue_req(32'hFFFF_FFFF, 48'h0000_0000_0005);
    queue_req(32'h5555_5555, 48'hAAAA_AAAA_AAAA);
    queue_req(32'hAAAA_AAAA, 48'h5555_5555_5555);
    drain();

    // no refill, capacity one: held tokens get clamped
    write_reg(RegRate, 32'h0000_0000);
    write_reg(RegBurst, 32'd1);
    queue_req(32'h0000_0000, 48'h0000_0000_000A);
    queue_req(32'h0000_0000, 48'h0000_0000_000B);
    queue_req(32'h0000_0000, 48'hFFFF_FFFF_FFFF);
    queue_req(32'h1234_5678, 48'h0000_0000_0014);
    queue_req(32'h1234_5678, 48'h0000_0000_0014);
    drain();

    // top rate and capacity: saturating product, just under one token
    write_reg(RegRate, 32'hFFFF_FFFF);
    write_reg(RegBurst, 32'd65535);
    queue_req(32'h0000_0000, 48'h7FFF_FFFF_FFFF);
    queue_req(32'h0000_0000, 48'h7FFF_FFFF_FFFF);
    queue_req(32'h1234_5678, 48'h0000_0000_0015);
    queue_req(32'h1234_5678, 48'h0000_0000_0016);
    queue_req(32'h8000_0001, 48'h8000_0000_0000);
    drain();

    // random traffic, three register settings and idle profiles
    req_clock = {$urandom(), $urandom()};
    write_reg(RegRate, 32'h0040_0000);
    write_reg(RegBurst, 32'd2);
    run_random(190, 31, 70);
    write_reg(RegRate, $urandom_range(32'h0100_0000, 1));
    write_reg(RegBurst, $urandom_range(4, 1));
    run_random(160, 66, 70);
    write_reg(RegRate, $urandom());
    write_reg(RegBurst, $urandom_range(65535, 1));
    run_random(250, 0, 92);

    repeat (TABLE_N + 16) @(posedge clk_i);
    $display("covered %0d requests: %0d granted, %0d refused", n_results, n_granted,
             n_results - n_granted);
    $display("%0d new buckets, %0d table flushes, %0d mismatches", n_fresh, n_flush,
             mismatches);
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("tb_keyed_token_bucket_limiter OK");
    end else begin
      $display("tb_keyed_token_bucket_limiter NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
design/ktb_pkg.sv
design/ktb_table.sv
design/ktb_arith.sv
design/keyed_token_bucket_limiter.sv
design/ktb_checker.sv
sim/tb_keyed_token_bucket_limiter.sv
